// ===== rtl/gdu_pkg.sv =====
package gdu_pkg;

    // Field widths of one input item.
    localparam int unsigned DayW   = 5;
    localparam int unsigned MonthW = 4;
    localparam int unsigned YearW  = 14;
    localparam int unsigned OrdW   = 9;

    // Packed widths of the stream data buses, padded to whole bytes.
    localparam int unsigned InFieldW  = DayW + MonthW + YearW;
    localparam int unsigned OutFieldW = 1 + DayW + OrdW + 2 * (DayW + MonthW + YearW);
    localparam int unsigned InDataW   = ((InFieldW + 7) / 8) * 8;
    localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

    // Calendar constants.
    localparam logic [MonthW-1:0] MonthJan = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthDec = 4'd12;
    localparam logic [YearW-1:0]  YearMax  = 14'd9999;
    localparam logic [DayW-1:0]   DaysDec  = 5'd31;

    // Division by 100 as a multiply by a scaled reciprocal. For any 14-bit
    // value the rounding error stays well below one step of the quotient.
    localparam int unsigned RecipW     = 13;
    localparam int unsigned RecipShift = 19;
    localparam logic [RecipW-1:0] Recip100 = 13'd5243;
    localparam int unsigned QuotW      = 8;
    localparam int unsigned ProdW      = YearW + RecipW;

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
    } t_date_in;

    typedef struct packed {
        logic [YearW-1:0]  prev_year;
        logic [MonthW-1:0] prev_month;
        logic [DayW-1:0]   prev_day;
        logic [YearW-1:0]  next_year;
        logic [MonthW-1:0] next_month;
        logic [DayW-1:0]   next_day;
        logic [OrdW-1:0]   ordinal_day;
        logic [DayW-1:0]   month_length;
        logic              date_valid;
    } t_date_out;

    // Days in a month; zero for a month number that does not exist.
    function automatic logic [DayW-1:0] month_days(
        input logic [MonthW-1:0] month,
        input logic              leap
    );
        logic [DayW-1:0] len;
        case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of a month in a common year.
    function automatic logic [OrdW-1:0] days_before(input logic [MonthW-1:0] month);
        logic [OrdW-1:0] cnt;
        case (month)
            4'd2:    cnt = 9'd31;
            4'd3:    cnt = 9'd59;
            4'd4:    cnt = 9'd90;
            4'd5:    cnt = 9'd120;
            4'd6:    cnt = 9'd151;
            4'd7:    cnt = 9'd181;
            4'd8:    cnt = 9'd212;
            4'd9:    cnt = 9'd243;
            4'd10:   cnt = 9'd273;
            4'd11:   cnt = 9'd304;
            4'd12:   cnt = 9'd334;
            default: cnt = 9'd0;
        endcase
        return cnt;
    endfunction

endpackage

// ===== rtl/gregorian_date_unit.sv =====
// Gregorian date unit: validity, month length, day of year, next and previous date.
// Items pass the input register, then the result register. One item per cycle unless
// the output stalls; an input register and a result register hold one item each, so
// while a result waits the input takes one more item and then stalls.
// Reset (i_rst_n low, synchronous) empties both registers; data is not cleared.
module gregorian_date_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0 up: day[4:0], month[8:5], year[22:9], zero padding.
    input  logic [gdu_pkg::InDataW-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0 up: date_valid, month_length, ordinal_day, next_day,
    // next_month, next_year, prev_day, prev_month, prev_year, zero padding.
    output logic [gdu_pkg::OutDataW-1:0]  m_axis_tdata
);

    logic                r_in_valid;
    gdu_pkg::t_date_in   r_in;
    logic                r_out_valid;
    gdu_pkg::t_date_out  r_out;

    logic                advance;
    gdu_pkg::t_date_out  n_out;

    logic [gdu_pkg::DayW-1:0]   d;
    logic [gdu_pkg::MonthW-1:0] m;
    logic [gdu_pkg::YearW-1:0]  y;
    logic [gdu_pkg::ProdW-1:0]  prod;
    logic [gdu_pkg::QuotW-1:0]  quot;
    logic [gdu_pkg::YearW:0]    quot_x100;
    logic                       div4;
    logic                       div100;
    logic                       leap;
    logic [gdu_pkg::DayW-1:0]   len;
    logic [gdu_pkg::DayW-1:0]   prev_len;
    logic                       valid;

    // Handshake: the input stage moves on when the result register is free.
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= s_axis_tdata[gdu_pkg::InFieldW-1:0];
        end
    end

    assign d = r_in.day;
    assign m = r_in.month;
    assign y = r_in.year;

    // Leap rule: divisible by 4, and not by 100 unless by 400.
    assign prod      = {{gdu_pkg::RecipW{1'b0}}, y} * {{gdu_pkg::YearW{1'b0}}, gdu_pkg::Recip100};
    assign quot      = prod[gdu_pkg::RecipShift +: gdu_pkg::QuotW];
    assign quot_x100 = {1'b0, quot, 6'b0} + {2'b0, quot, 5'b0} + {5'b0, quot, 2'b0};
    assign div4      = (y[1:0] == 2'b00);
    assign div100    = (quot_x100 == {1'b0, y});
    assign leap      = div4 && (!div100 || (quot[1:0] == 2'b00));

    assign len      = gdu_pkg::month_days(m, leap);
    assign prev_len = gdu_pkg::month_days(m - 4'd1, leap);

    // A real date needs a month that exists, a year in range and a day in the month.
    assign valid = (len != '0) && (y != '0) && (y <= gdu_pkg::YearMax)
                && (d != '0) && (d <= len);

    // Result of one item; everything but the flag stays zero for an invalid date.
    always_comb begin
        n_out = '0;
        if (valid) begin
            n_out.date_valid   = 1'b1;
            n_out.month_length = len;
            n_out.ordinal_day  = gdu_pkg::days_before(m) + {4'b0, d}
                               + {8'b0, (m > gdu_pkg::MonthFeb) && leap};

            // Following date.
            n_out.next_day   = d + 5'd1;
            n_out.next_month = m;
            n_out.next_year  = y;
            if (d == len) begin
                n_out.next_day = 5'd1;
                if (m == gdu_pkg::MonthDec) begin
                    n_out.next_month = gdu_pkg::MonthJan;
                    n_out.next_year  = y + 14'd1;
                end else begin
                    n_out.next_month = m + 4'd1;
                end
            end

            // Preceding date.
            n_out.prev_day   = d - 5'd1;
            n_out.prev_month = m;
            n_out.prev_year  = y;
            if (d == 5'd1) begin
                if (m == gdu_pkg::MonthJan) begin
                    n_out.prev_month = gdu_pkg::MonthDec;
                    n_out.prev_year  = y - 14'd1;
                    n_out.prev_day   = gdu_pkg::DaysDec;
                end else begin
                    n_out.prev_month = m - 4'd1;
                    n_out.prev_day   = prev_len;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(gdu_pkg::OutDataW - gdu_pkg::OutFieldW){1'b0}}, r_out};

endmodule
